FILE: rtl/pox_pkg.sv
// Shared constants, register indexes and widths for the pulse-oximetry block.
package pox_pkg;

    localparam int SAMPLE_BITS_DEF = 18;
    localparam int BPM_SLOTS_DEF   = 4;

    localparam int ACW    = 48;   // AC energy sums
    localparam int RTW    = 24;   // square root of an AC sum
    localparam int DVW    = 56;   // divider dividend / quotient
    localparam int DSW    = 40;   // divider divisor / remainder
    localparam int NORM_W = 40;   // R terms are brought below 2^NORM_W
    localparam int MUL_BW = 25;   // narrow multiplier operand, signed
    localparam int QDEPTH = 2;    // item queue between front and engine

    localparam int SPO2_W         = 24;
    localparam int K_SLOPE_Q8     = 5965;
    localparam int K_OFFSET_Q16   = 26214;
    localparam int SPO2_HUNDRED   = 25600;
    localparam int SPO2_FLOOR     = 20480;
    localparam int SPO2_RESET     = 24320;
    localparam int S24_MAX        = 8388607;
    localparam int S24_MIN        = -8388608;
    localparam int BPM_DIVIDEND   = 60000;
    localparam int BPM_LOW        = 20;
    localparam int BPM_HIGH       = 255;

    localparam logic [15:0] DC_WEIGHT_RST   = 16'd62259;
    localparam logic [15:0] SPO2_SMOOTH_RST = 16'd45875;
    localparam logic [9:0]  WINDOW_LEN_RST  = 10'd200;
    localparam logic [17:0] FINGER_THR_RST  = 18'd30000;
    localparam logic [7:0]  CHECK_PER_RST   = 8'd5;
    localparam logic [15:0] BOOT_TIME_RST   = 16'd3000;

    typedef enum logic [2:0] {
        REG_DC_WEIGHT   = 3'd0,
        REG_SPO2_SMOOTH = 3'd1,
        REG_WINDOW_LEN  = 3'd2,
        REG_FINGER_THR  = 3'd3,
        REG_CHECK_PER   = 3'd4,
        REG_BOOT_TIME   = 3'd5
    } reg_idx_t;

endpackage

FILE: rtl/pox_div.sv
// Restoring divider, one quotient bit per cycle.
module pox_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [pox_pkg::DVW-1:0] dividend,
    input  logic [pox_pkg::DSW-1:0] divisor,
    output logic                    done,
    output logic [pox_pkg::DVW-1:0] quotient,
    output logic [pox_pkg::DSW-1:0] remainder
);
    import pox_pkg::*;

    localparam int CNTW = $clog2(DVW);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DSW:0]    rem_reg, rem_next;
    logic [DVW-1:0]  quo_reg, quo_next;
    logic [DSW-1:0]  dsr_reg, dsr_next;

    always_comb begin
        logic [DSW:0] trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg[DSW-1:0], quo_reg[DVW-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = trial - {1'b0, dsr_reg};
                quo_next = {quo_reg[DVW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[DVW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(DVW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[DSW-1:0];

endmodule

FILE: rtl/pox_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
module pox_sqrt (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [pox_pkg::ACW-1:0] value,
    output logic                    done,
    output logic [pox_pkg::RTW-1:0] root
);
    import pox_pkg::*;

    localparam int STEPS = ACW / 2;
    localparam int CNTW  = $clog2(STEPS);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [ACW-1:0]  v_reg, v_next;
    logic [ACW-1:0]  r_reg, r_next;
    logic [ACW-1:0]  b_reg, b_next;

    always_comb begin
        logic [ACW:0] rb;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        rb        = {1'b0, r_reg} + {1'b0, b_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            v_next    = value;
            r_next    = '0;
            b_next    = {2'b01, {(ACW-2){1'b0}}};
        end else if (busy_reg) begin
            if ({1'b0, v_reg} >= rb) begin
                v_next = v_reg - rb[ACW-1:0];
                r_next = (r_reg >> 1) + b_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            b_next   = b_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        v_reg   <= v_next;
        r_reg   <= r_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign root = r_reg[RTW-1:0];

endmodule

FILE: rtl/pox_front.sv
// Input front: accepts items, tags beat intervals, queues them for the engine.
module pox_front #(
    parameter int SAMPLE_BITS = pox_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_red_sample,
    input  logic [SAMPLE_BITS-1:0] s_ir_sample,
    input  logic [31:0]            s_time_ms,
    input  logic                   s_beat_seen,
    output logic                   q_valid,
    input  logic                   q_pop,
    output logic [SAMPLE_BITS-1:0] q_red,
    output logic [SAMPLE_BITS-1:0] q_ir,
    output logic [31:0]            q_time,
    output logic                   q_rate,
    output logic [31:0]            q_delta
);
    import pox_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    logic [SAMPLE_BITS-1:0] red_reg   [QDEPTH];
    logic [SAMPLE_BITS-1:0] ir_reg    [QDEPTH];
    logic [31:0]            time_reg  [QDEPTH];
    logic                   rate_reg  [QDEPTH];
    logic [31:0]            delta_reg [QDEPTH];
    logic [PW-1:0]          wr_reg, wr_next;
    logic [PW-1:0]          rd_reg, rd_next;
    logic [PW:0]            cnt_reg, cnt_next;
    logic [31:0]            last_reg, last_next;
    logic                   accept;
    logic                   pop;
    logic [31:0]            delta;

    assign s_ready = (cnt_reg != (PW+1)'(QDEPTH));
    assign accept  = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign pop     = q_pop && q_valid;
    assign delta   = s_time_ms - last_reg;

    always_comb begin
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        if (accept) begin
            wr_next = (wr_reg == PW'(QDEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (s_beat_seen) begin
                last_next = s_time_ms;
            end
        end
        if (pop) begin
            rd_next = (rd_reg == PW'(QDEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (accept && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!accept && pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            cnt_reg  <= '0;
            last_reg <= '0;
        end else begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
        end
        if (accept) begin
            red_reg[wr_reg]   <= s_red_sample;
            ir_reg[wr_reg]    <= s_ir_sample;
            time_reg[wr_reg]  <= s_time_ms;
            rate_reg[wr_reg]  <= s_beat_seen && (delta != '0);
            delta_reg[wr_reg] <= delta;
        end
    end

    assign q_red   = red_reg[rd_reg];
    assign q_ir    = ir_reg[rd_reg];
    assign q_time  = time_reg[rd_reg];
    assign q_rate  = rate_reg[rd_reg];
    assign q_delta = delta_reg[rd_reg];

endmodule

FILE: rtl/pox_engine.sv
// Back-end sequencer: DC/AC tracking, beat-rate ring and SpO2 window math.
module pox_engine #(
    parameter int SAMPLE_BITS = pox_pkg::SAMPLE_BITS_DEF,
    parameter int BPM_SLOTS   = pox_pkg::BPM_SLOTS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_pop,
    input  logic [SAMPLE_BITS-1:0] q_red,
    input  logic [SAMPLE_BITS-1:0] q_ir,
    input  logic [31:0]            q_time,
    input  logic                   q_rate,
    input  logic [31:0]            q_delta,
    input  logic [15:0]            dc_weight_q16,
    input  logic [15:0]            spo2_smooth_q16,
    input  logic [9:0]             window_length,
    input  logic [17:0]            finger_threshold,
    input  logic [7:0]             check_period,
    input  logic [15:0]            boot_time_ms,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [15:0]     m_spo2_estimate,
    output logic [7:0]             m_bpm_average,
    output logic                   m_window_done
);
    import pox_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int DCW  = SB + 16;
    localparam int AW   = DCW + 1;
    localparam int BW   = MUL_BW;
    localparam int PW   = AW + BW;
    localparam int NW   = RTW + DCW;
    localparam int PTRW = (BPM_SLOTS > 1) ? $clog2(BPM_SLOTS) : 1;
    localparam int SUMW = $clog2(BPM_SLOTS * 256);
    // ring mean by reciprocal multiplication, exact for every reachable sum
    localparam int MEAN_SH  = 24;
    localparam int MEAN_RCP = ((1 << MEAN_SH) + BPM_SLOTS - 1) / BPM_SLOTS;
    localparam int MPW      = SUMW + MEAN_SH;

    typedef enum logic [25:0] {
        ST_IDLE   = 26'h1 << 0,
        ST_RATE   = 26'h1 << 1,
        ST_RATE_W = 26'h1 << 2,
        ST_MEAN   = 26'h1 << 3,
        ST_DC_A   = 26'h1 << 4,
        ST_DC_B   = 26'h1 << 5,
        ST_DC_C   = 26'h1 << 6,
        ST_AC_A   = 26'h1 << 7,
        ST_AC_B   = 26'h1 << 8,
        ST_MOD    = 26'h1 << 9,
        ST_MOD_W  = 26'h1 << 10,
        ST_WIN    = 26'h1 << 11,
        ST_SQ     = 26'h1 << 12,
        ST_SQ_W   = 26'h1 << 13,
        ST_CHK    = 26'h1 << 14,
        ST_NUM    = 26'h1 << 15,
        ST_DEN    = 26'h1 << 16,
        ST_NORM   = 26'h1 << 17,
        ST_R_W    = 26'h1 << 18,
        ST_SLOPE  = 26'h1 << 19,
        ST_RAW    = 26'h1 << 20,
        ST_SM_A   = 26'h1 << 21,
        ST_SM_B   = 26'h1 << 22,
        ST_SM_C   = 26'h1 << 23,
        ST_CLR    = 26'h1 << 24,
        ST_OUT    = 26'h1 << 25
    } state_t;

    state_t                   state_reg, state_next;
    logic                     ch_reg, ch_next;
    logic [SB-1:0]            red_reg, red_next;
    logic [SB-1:0]            ir_reg, ir_next;
    logic [31:0]              time_reg, time_next;
    logic [31:0]              delta_reg, delta_next;
    logic [DCW-1:0]           dc_red_reg, dc_red_next;
    logic [DCW-1:0]           dc_ir_reg, dc_ir_next;
    logic [DCW-1:0]           tmp_reg, tmp_next;
    logic [ACW-1:0]           acc_red_reg, acc_red_next;
    logic [ACW-1:0]           acc_ir_reg, acc_ir_next;
    logic [9:0]               idx_reg, idx_next;
    logic signed [SPO2_W-1:0] spo2_reg, spo2_next;
    logic signed [SPO2_W-1:0] raw_reg, raw_next;
    logic [7:0]               slot_reg [BPM_SLOTS];
    logic [7:0]               slot_next [BPM_SLOTS];
    logic [PTRW-1:0]          ptr_reg, ptr_next;
    logic [SUMW-1:0]          sum_reg, sum_next;
    logic [7:0]               mean_reg, mean_next;
    logic [RTW-1:0]           rs_reg, rs_next;
    logic [RTW-1:0]           is_reg, is_next;
    logic [NW-1:0]            num_reg, num_next;
    logic [NW-1:0]            den_reg, den_next;
    logic [31:0]              r_reg, r_next;
    logic signed [PW-1:0]     tacc_reg, tacc_next;
    logic signed [PW-1:0]     prod_reg;
    logic                     done_reg, done_next;
    logic                     mv_reg, mv_next;
    logic signed [15:0]       mspo2_reg, mspo2_next;
    logic [7:0]               mbpm_reg, mbpm_next;
    logic                     mdone_reg, mdone_next;

    logic signed [AW-1:0]     mul_a;
    logic signed [BW-1:0]     mul_b;
    logic                     div_start, div_done;
    logic [DVW-1:0]           div_dividend, div_quot;
    logic [DSW-1:0]           div_divisor, div_rem;
    logic                     sqrt_start, sqrt_done;
    logic [ACW-1:0]           sqrt_value;
    logic [RTW-1:0]           sqrt_root;

    pox_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    pox_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .value   (sqrt_value),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    always_comb begin
        logic [SB-1:0]        s_cur;
        logic [DCW-1:0]       dc_cur;
        logic [ACW-1:0]       acc_cur;
        logic [SB-1:0]        dc_int;
        logic [SB-1:0]        dev;
        logic [16:0]          inv_dw;
        logic [16:0]          inv_sw;
        logic [ACW:0]         acc_sum;
        logic signed [32:0]   r_off;
        logic signed [PW-1:0] slope;
        logic signed [PW:0]   raw_full;
        logic signed [PW-1:0] t_sum;
        logic                 bpm_ok;
        logic [MPW-1:0]       mean_prod;

        s_cur   = ch_reg ? ir_reg : red_reg;
        dc_cur  = ch_reg ? dc_ir_reg : dc_red_reg;
        acc_cur = ch_reg ? acc_ir_reg : acc_red_reg;
        dc_int  = dc_cur[DCW-1:16];
        dev     = (s_cur >= dc_int) ? s_cur - dc_int : dc_int - s_cur;
        inv_dw  = 17'h10000 - {1'b0, dc_weight_q16};
        inv_sw  = 17'h10000 - {1'b0, spo2_smooth_q16};
        acc_sum = {1'b0, acc_cur} + {1'b0, prod_reg[ACW-1:0]};
        r_off   = $signed({1'b0, r_reg}) - 33'sd26214;
        slope   = prod_reg >>> 16;
        raw_full = (PW+1)'(SPO2_HUNDRED) - {slope[PW-1], slope};
        t_sum   = tacc_reg + prod_reg;
        bpm_ok  = (div_quot > DVW'(BPM_LOW)) && (div_quot < DVW'(BPM_HIGH));
        mean_prod = MPW'(sum_reg) * MPW'(MEAN_RCP);

        state_next   = state_reg;
        ch_next      = ch_reg;
        red_next     = red_reg;
        ir_next      = ir_reg;
        time_next    = time_reg;
        delta_next   = delta_reg;
        dc_red_next  = dc_red_reg;
        dc_ir_next   = dc_ir_reg;
        tmp_next     = tmp_reg;
        acc_red_next = acc_red_reg;
        acc_ir_next  = acc_ir_reg;
        idx_next     = idx_reg;
        spo2_next    = spo2_reg;
        raw_next     = raw_reg;
        slot_next    = slot_reg;
        ptr_next     = ptr_reg;
        sum_next     = sum_reg;
        mean_next    = mean_reg;
        rs_next      = rs_reg;
        is_next      = is_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        r_next       = r_reg;
        tacc_next    = tacc_reg;
        done_next    = done_reg;
        mspo2_next   = mspo2_reg;
        mbpm_next    = mbpm_reg;
        mdone_next   = mdone_reg;
        mv_next      = mv_reg && !m_ready;

        q_pop        = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        sqrt_start   = 1'b0;
        sqrt_value   = ch_reg ? acc_ir_reg : acc_red_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    red_next   = q_red;
                    ir_next    = q_ir;
                    time_next  = q_time;
                    delta_next = q_delta;
                    idx_next   = idx_reg + 1'b1;
                    ch_next    = 1'b0;
                    done_next  = 1'b0;
                    state_next = q_rate ? ST_RATE : ST_DC_A;
                end
            end
            ST_RATE: begin
                div_start    = 1'b1;
                div_dividend = DVW'(BPM_DIVIDEND);
                div_divisor  = {{(DSW-32){1'b0}}, delta_reg};
                state_next   = ST_RATE_W;
            end
            ST_RATE_W: begin
                if (div_done) begin
                    if (bpm_ok) begin
                        // replace the oldest slot and keep the ring sum current
                        slot_next[ptr_reg] = div_quot[7:0];
                        sum_next = sum_reg - {{(SUMW-8){1'b0}}, slot_reg[ptr_reg]}
                                 + {{(SUMW-8){1'b0}}, div_quot[7:0]};
                        ptr_next = (ptr_reg == PTRW'(BPM_SLOTS - 1)) ? '0
                                 : ptr_reg + 1'b1;
                        state_next = ST_MEAN;
                    end else begin
                        state_next = ST_DC_A;
                    end
                end
            end
            ST_MEAN: begin
                mean_next  = mean_prod[MEAN_SH+7:MEAN_SH];
                state_next = ST_DC_A;
            end
            ST_DC_A: begin
                mul_a      = {1'b0, dc_cur};
                mul_b      = {{(BW-16){1'b0}}, dc_weight_q16};
                state_next = ST_DC_B;
            end
            ST_DC_B: begin
                tmp_next   = prod_reg[DCW+15:16];
                mul_a      = {{(AW-SB){1'b0}}, s_cur};
                mul_b      = {{(BW-17){1'b0}}, inv_dw};
                state_next = ST_DC_C;
            end
            ST_DC_C: begin
                if (ch_reg) begin
                    dc_ir_next = tmp_reg + prod_reg[DCW-1:0];
                end else begin
                    dc_red_next = tmp_reg + prod_reg[DCW-1:0];
                end
                state_next = ST_AC_A;
            end
            ST_AC_A: begin
                mul_a      = {{(AW-SB){1'b0}}, dev};
                mul_b      = {{(BW-SB){1'b0}}, dev};
                state_next = ST_AC_B;
            end
            ST_AC_B: begin
                // saturate the energy sum at full scale
                if (ch_reg) begin
                    acc_ir_next = acc_sum[ACW] ? '1 : acc_sum[ACW-1:0];
                    ch_next     = 1'b0;
                    state_next  = ST_MOD;
                end else begin
                    acc_red_next = acc_sum[ACW] ? '1 : acc_sum[ACW-1:0];
                    ch_next      = 1'b1;
                    state_next   = ST_DC_A;
                end
            end
            ST_MOD: begin
                if (check_period != '0) begin
                    div_start    = 1'b1;
                    div_dividend = {{(DVW-10){1'b0}}, idx_reg};
                    div_divisor  = {{(DSW-8){1'b0}}, check_period};
                    state_next   = ST_MOD_W;
                end else begin
                    state_next = ST_WIN;
                end
            end
            ST_MOD_W: begin
                if (div_done) begin
                    if (div_rem == '0 && time_reg > {16'b0, boot_time_ms}
                        && {{(32-SB){1'b0}}, ir_reg} < {14'b0, finger_threshold}) begin
                        spo2_next = SPO2_W'(SPO2_FLOOR);
                    end
                    state_next = ST_WIN;
                end
            end
            ST_WIN: begin
                if (idx_reg >= window_length) begin
                    done_next  = 1'b1;
                    ch_next    = 1'b0;
                    state_next = ST_SQ;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_SQ: begin
                sqrt_start = 1'b1;
                state_next = ST_SQ_W;
            end
            ST_SQ_W: begin
                if (sqrt_done) begin
                    if (ch_reg) begin
                        is_next    = sqrt_root;
                        ch_next    = 1'b0;
                        state_next = ST_CHK;
                    end else begin
                        rs_next    = sqrt_root;
                        ch_next    = 1'b1;
                        state_next = ST_SQ;
                    end
                end
            end
            ST_CHK: begin
                // zero divisor or zero IR DC level: keep the estimate, still close the window
                if (dc_red_reg == '0 || dc_ir_reg == '0 || is_reg == '0) begin
                    state_next = ST_CLR;
                end else begin
                    mul_a      = {1'b0, dc_ir_reg};
                    mul_b      = {{(BW-RTW){1'b0}}, rs_reg};
                    state_next = ST_NUM;
                end
            end
            ST_NUM: begin
                num_next   = prod_reg[NW-1:0];
                mul_a      = {1'b0, dc_red_reg};
                mul_b      = {{(BW-RTW){1'b0}}, is_reg};
                state_next = ST_DEN;
            end
            ST_DEN: begin
                den_next   = prod_reg[NW-1:0];
                state_next = ST_NORM;
            end
            ST_NORM: begin
                if ((num_reg[NW-1:NORM_W] != '0) || (den_reg[NW-1:NORM_W] != '0)) begin
                    num_next = num_reg >> 1;
                    den_next = den_reg >> 1;
                end else if (den_reg == '0) begin
                    r_next     = '1;
                    state_next = ST_SLOPE;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = {num_reg[NORM_W-1:0], 16'b0};
                    div_divisor  = den_reg[DSW-1:0];
                    state_next   = ST_R_W;
                end
            end
            ST_R_W: begin
                if (div_done) begin
                    r_next     = (div_quot[DVW-1:32] != '0) ? '1 : div_quot[31:0];
                    state_next = ST_SLOPE;
                end
            end
            ST_SLOPE: begin
                mul_a      = {{(AW-33){r_off[32]}}, r_off};
                mul_b      = BW'(K_SLOPE_Q8);
                state_next = ST_RAW;
            end
            ST_RAW: begin
                if (raw_full > (PW+1)'(S24_MAX)) begin
                    raw_next = SPO2_W'(S24_MAX);
                end else if (raw_full < (PW+1)'(S24_MIN)) begin
                    raw_next = SPO2_W'(S24_MIN);
                end else begin
                    raw_next = raw_full[SPO2_W-1:0];
                end
                state_next = ST_SM_A;
            end
            ST_SM_A: begin
                mul_a      = {{(AW-SPO2_W){spo2_reg[SPO2_W-1]}}, spo2_reg};
                mul_b      = {{(BW-16){1'b0}}, spo2_smooth_q16};
                state_next = ST_SM_B;
            end
            ST_SM_B: begin
                tacc_next  = prod_reg;
                mul_a      = {{(AW-SPO2_W){raw_reg[SPO2_W-1]}}, raw_reg};
                mul_b      = {{(BW-17){1'b0}}, inv_sw};
                state_next = ST_SM_C;
            end
            ST_SM_C: begin
                spo2_next  = t_sum[SPO2_W+15:16];
                state_next = ST_CLR;
            end
            ST_CLR: begin
                acc_red_next = '0;
                acc_ir_next  = '0;
                idx_next     = '0;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    if (spo2_reg > 24'sd32767) begin
                        mspo2_next = 16'sh7FFF;
                    end else if (spo2_reg < -24'sd32768) begin
                        mspo2_next = 16'sh8000;
                    end else begin
                        mspo2_next = spo2_reg[15:0];
                    end
                    mbpm_next  = mean_reg;
                    mdone_next = done_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ch_reg      <= 1'b0;
            dc_red_reg  <= '0;
            dc_ir_reg   <= '0;
            acc_red_reg <= '0;
            acc_ir_reg  <= '0;
            idx_reg     <= '0;
            spo2_reg    <= SPO2_W'(SPO2_RESET);
            for (int k = 0; k < BPM_SLOTS; k++) begin
                slot_reg[k] <= '0;
            end
            ptr_reg     <= '0;
            sum_reg     <= '0;
            mean_reg    <= '0;
            done_reg    <= 1'b0;
            mv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            dc_red_reg  <= dc_red_next;
            dc_ir_reg   <= dc_ir_next;
            acc_red_reg <= acc_red_next;
            acc_ir_reg  <= acc_ir_next;
            idx_reg     <= idx_next;
            spo2_reg    <= spo2_next;
            slot_reg    <= slot_next;
            ptr_reg     <= ptr_next;
            sum_reg     <= sum_next;
            mean_reg    <= mean_next;
            done_reg    <= done_next;
            mv_reg      <= mv_next;
        end
        red_reg   <= red_next;
        ir_reg    <= ir_next;
        time_reg  <= time_next;
        delta_reg <= delta_next;
        tmp_reg   <= tmp_next;
        raw_reg   <= raw_next;
        rs_reg    <= rs_next;
        is_reg    <= is_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        r_reg     <= r_next;
        tacc_reg  <= tacc_next;
        prod_reg  <= mul_a * mul_b;
        mspo2_reg <= mspo2_next;
        mbpm_reg  <= mbpm_next;
        mdone_reg <= mdone_next;
    end

    assign m_valid         = mv_reg;
    assign m_spo2_estimate = mspo2_reg;
    assign m_bpm_average   = mbpm_reg;
    assign m_window_done   = mdone_reg;

endmodule

FILE: rtl/pulse_oximetry_spo2_bpm.sv
// Pulse-oximetry SpO2 / heart-rate top: APB register file, item front and engine.
// Timing: the 56-step shared divider and the 24-step root set the per-item time; it grows
//   when an item carries a beat interval, and again at a window end.
// Throughput: one item in flight in the engine; a two-item queue and the result register
//   let the input and output sides stall independently.
// Reset (aresetn low, synchronous): registers to defaults, estimate to 95.0, ring cleared.
module pulse_oximetry_spo2_bpm #(
    parameter int SAMPLE_BITS = pox_pkg::SAMPLE_BITS_DEF,
    parameter int BPM_SLOTS   = pox_pkg::BPM_SLOTS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // APB register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // sample items in
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_red_sample,
    input  logic [SAMPLE_BITS-1:0] s_ir_sample,
    input  logic [31:0]            s_time_ms,
    input  logic                   s_beat_seen,
    // result items out
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [15:0]     m_spo2_estimate,
    output logic [7:0]             m_bpm_average,
    output logic                   m_window_done
);
    import pox_pkg::*;

    logic [15:0] dc_weight_reg, dc_weight_next;
    logic [15:0] smooth_reg, smooth_next;
    logic [9:0]  win_len_reg, win_len_next;
    logic [17:0] thr_reg, thr_next;
    logic [7:0]  period_reg, period_next;
    logic [15:0] boot_reg, boot_next;
    logic        wr_en;
    reg_idx_t    reg_idx;

    logic                   q_valid;
    logic                   q_pop;
    logic [SAMPLE_BITS-1:0] q_red;
    logic [SAMPLE_BITS-1:0] q_ir;
    logic [31:0]            q_time;
    logic                   q_rate;
    logic [31:0]            q_delta;

    // Registers sit at byte address 4*index; the write lands in the access phase.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[4:2]);

    always_comb begin
        dc_weight_next = dc_weight_reg;
        smooth_next    = smooth_reg;
        win_len_next   = win_len_reg;
        thr_next       = thr_reg;
        period_next    = period_reg;
        boot_next      = boot_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_DC_WEIGHT:   dc_weight_next = pwdata[15:0];
                REG_SPO2_SMOOTH: smooth_next    = pwdata[15:0];
                REG_WINDOW_LEN:  win_len_next   = pwdata[9:0];
                REG_FINGER_THR:  thr_next       = pwdata[17:0];
                REG_CHECK_PER:   period_next    = pwdata[7:0];
                REG_BOOT_TIME:   boot_next      = pwdata[15:0];
                default: begin
                    // addresses past the register list: drop the write
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DC_WEIGHT:   prdata = {16'b0, dc_weight_reg};
            REG_SPO2_SMOOTH: prdata = {16'b0, smooth_reg};
            REG_WINDOW_LEN:  prdata = {22'b0, win_len_reg};
            REG_FINGER_THR:  prdata = {14'b0, thr_reg};
            REG_CHECK_PER:   prdata = {24'b0, period_reg};
            REG_BOOT_TIME:   prdata = {16'b0, boot_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dc_weight_reg <= DC_WEIGHT_RST;
            smooth_reg    <= SPO2_SMOOTH_RST;
            win_len_reg   <= WINDOW_LEN_RST;
            thr_reg       <= FINGER_THR_RST;
            period_reg    <= CHECK_PER_RST;
            boot_reg      <= BOOT_TIME_RST;
        end else begin
            dc_weight_reg <= dc_weight_next;
            smooth_reg    <= smooth_next;
            win_len_reg   <= win_len_next;
            thr_reg       <= thr_next;
            period_reg    <= period_next;
            boot_reg      <= boot_next;
        end
    end

    // Front: take items, work out the beat interval, hold them in a short queue.
    pox_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red_sample (s_red_sample),
        .s_ir_sample  (s_ir_sample),
        .s_time_ms    (s_time_ms),
        .s_beat_seen  (s_beat_seen),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_red        (q_red),
        .q_ir         (q_ir),
        .q_time       (q_time),
        .q_rate       (q_rate),
        .q_delta      (q_delta)
    );

    // Engine: per-item DC/AC update, beat ring, and the SpO2 window computation.
    pox_engine #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .BPM_SLOTS   (BPM_SLOTS)
    ) u_engine (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_red            (q_red),
        .q_ir             (q_ir),
        .q_time           (q_time),
        .q_rate           (q_rate),
        .q_delta          (q_delta),
        .dc_weight_q16    (dc_weight_reg),
        .spo2_smooth_q16  (smooth_reg),
        .window_length    (win_len_reg),
        .finger_threshold (thr_reg),
        .check_period     (period_reg),
        .boot_time_ms     (boot_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_spo2_estimate  (m_spo2_estimate),
        .m_bpm_average    (m_bpm_average),
        .m_window_done    (m_window_done)
    );

endmodule
